FILE: hdl/median_filter_5x5_top_defines.svh
// Assertion helpers for the median filter. They expect clk and arst_n in scope.
`ifndef MEDIAN_FILTER_5X5_TOP_DEFINES_SVH
`define MEDIAN_FILTER_5X5_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MF5_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define MF5_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/mf5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mf5_pkg;

	localparam int WINDOW     = 5;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int HALF       = (WINDOW - 1) / 2;
	localparam int TAPS       = WINDOW * WINDOW;
	localparam int LINES      = WINDOW - 1;
	localparam int CHANS      = 3;
	localparam int CW         = 8;
	localparam int PIX_W      = CHANS * CW;
	localparam int LINE_W     = LINES * PIX_W;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;
	localparam int ROW_W      = 13;
	localparam int LAG_W      = $clog2(HALF * MAX_WIDTH + HALF + 1);
	localparam int RANK_W     = $clog2(TAPS);
	localparam int ADDR_W     = 4;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COLOR_MODE   = 2'd2;

	localparam logic [WID_W-1:0] RST_FRAME_WIDTH  = WID_W'(1024);
	localparam logic [HGT_W-1:0] RST_FRAME_HEIGHT = HGT_W'(1024);
	localparam logic             RST_COLOR_MODE   = 1'b1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef logic [CW-1:0]     chan_t;
	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [WID_W-1:0]  wid_t;
	typedef logic [HGT_W-1:0]  hgt_t;
	typedef logic [LAG_W-1:0]  lag_t;
	typedef logic [WINDOW-1:0] mask_t;
	typedef pix_t [WINDOW-1:0][WINDOW-1:0] win_t;
	typedef chan_t [TAPS-1:0] taps_t;

	typedef struct packed {
		logic valid;
		col_t col;
		pix_t px;
	} wr_req_t;

endpackage

`default_nettype wire

FILE: hdl/mf5_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mf5_pix_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [7:0] chan0;
	logic [7:0] chan1;
	logic [7:0] chan2;

	modport source (output valid, cmd, chan0, chan1, chan2, input ready);
	modport sink (input valid, cmd, chan0, chan1, chan2, output ready);
endinterface

interface mf5_res_if;
	logic valid;
	logic ready;
	logic [7:0] med0;
	logic [7:0] med1;
	logic [7:0] med2;
	logic frame_end;

	modport source (output valid, med0, med1, med2, frame_end, input ready);
	modport sink (input valid, med0, med1, med2, frame_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/mf5_window.sv
`timescale 1ns / 1ps
`default_nettype none

module mf5_window (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire mf5_pkg::wr_req_t req,
	output mf5_pkg::win_t        win
);

	logic [mf5_pkg::LINE_W-1:0] mem [mf5_pkg::MAX_WIDTH];
	logic [mf5_pkg::LINE_W-1:0] rd_q;
	logic [mf5_pkg::LINE_W-1:0] byp_q;
	logic                       byp_sel_q;
	logic                       v_s1;
	mf5_pkg::col_t              col_s1;
	mf5_pkg::pix_t              px_s1;
	logic [mf5_pkg::LINE_W-1:0] old_word;
	logic [mf5_pkg::LINE_W-1:0] new_word;
	mf5_pkg::pix_t [mf5_pkg::WINDOW-1:0] column;
	mf5_pkg::win_t              win_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q <= mem[req.col];
		end
		if (en && v_s1) begin
			mem[col_s1] <= new_word;
		end
	end

	// A word read at the same edge as the write to its column takes the new data instead.
	always_ff @(posedge clk) begin
		if (en) begin
			byp_q     <= new_word;
			byp_sel_q <= v_s1 && (req.col == col_s1);
			col_s1    <= req.col;
			px_s1     <= req.px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	// Slot k of a line word holds the row k + 1 above the incoming one.
	always_comb begin
		old_word = byp_sel_q ? byp_q : rd_q;
		new_word = {old_word[mf5_pkg::LINE_W-mf5_pkg::PIX_W-1:0], px_s1};
		column[mf5_pkg::WINDOW-1] = px_s1;
		for (int k = 0; k < mf5_pkg::LINES; k++) begin
			column[mf5_pkg::WINDOW-2-k] = old_word[k*mf5_pkg::PIX_W +: mf5_pkg::PIX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			for (int i = 0; i < mf5_pkg::WINDOW; i++) begin
				for (int j = 0; j < mf5_pkg::WINDOW - 1; j++) begin
					win_s2[i][j] <= win_s2[i][j+1];
				end
				win_s2[i][mf5_pkg::WINDOW-1] <= column[i];
			end
		end
	end

	assign win = win_s2;

endmodule

`default_nettype wire

FILE: hdl/mf5_median_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module mf5_median_lane (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire mf5_pkg::taps_t taps,
	output mf5_pkg::chan_t      med
);

	mf5_pkg::taps_t vals_s3;
	mf5_pkg::taps_t vals_s4;
	logic [mf5_pkg::TAPS-1:0][mf5_pkg::TAPS-1:0] lt_s3;
	logic [mf5_pkg::TAPS-1:0][mf5_pkg::RANK_W-1:0] rank_s4;
	mf5_pkg::chan_t med_s5;
	logic [mf5_pkg::TAPS-1:0][mf5_pkg::RANK_W-1:0] rank;
	mf5_pkg::chan_t sel;

	// Ties are broken by position, so every element gets a distinct rank.
	always_ff @(posedge clk) begin
		if (en) begin
			vals_s3 <= taps;
			for (int i = 0; i < mf5_pkg::TAPS; i++) begin
				for (int j = 0; j < mf5_pkg::TAPS; j++) begin
					lt_s3[i][j] <= (taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i));
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < mf5_pkg::TAPS; i++) begin
			rank[i] = mf5_pkg::RANK_W'($countones(lt_s3[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vals_s4 <= vals_s3;
			rank_s4 <= rank;
		end
	end

	always_comb begin
		sel = '0;
		for (int i = 0; i < mf5_pkg::TAPS; i++) begin
			if (rank_s4[i] == mf5_pkg::RANK_W'(mf5_pkg::TAPS / 2)) begin
				sel = sel | vals_s4[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			med_s5 <= sel;
		end
	end

	assign med = med_s5;

endmodule

`default_nettype wire

FILE: hdl/median_filter_5x5_top.sv
// Channel  | Direction | Carries
// pix      | in        | cmd, chan0..chan2 (one pixel or flush word)
// res      | out       | med0..med2, frame_end
// APB      | in        | frame_width, frame_height, color_mode at 0x0, 0x4, 0x8
//
// One word is taken per clock unless a result is stalled; a result leaves the pipeline
// after the word that completes its window, two rows and two columns behind the input.
// The rate is set by the line memory, which has one read and one write port, each used
// once per word.
// Reset is asynchronous; the line memory is not cleared, rows outside the image are masked.
// A stalled result holds the whole pipeline, and pix.ready drops in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_5x5_top_defines.svh"

module median_filter_5x5_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mf5_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	mf5_pix_if.sink                         pix,
	mf5_res_if.source                       res
);

	mf5_pkg::wid_t cfg_width_q;
	mf5_pkg::hgt_t cfg_height_q;
	logic          cfg_color_q;
	logic [1:0]    reg_idx;

	logic          busy_q;
	mf5_pkg::wid_t act_w_q;
	mf5_pkg::hgt_t act_h_q;
	logic          act_color_q;
	mf5_pkg::row_t in_row_q;
	mf5_pkg::col_t in_col_q;
	mf5_pkg::row_t out_row_q;
	mf5_pkg::col_t out_col_q;
	mf5_pkg::lag_t lag_q;

	logic          en;
	logic          start;
	logic          take;
	mf5_pkg::wid_t w_clamp;
	mf5_pkg::hgt_t h_clamp;
	mf5_pkg::wid_t w_eff;
	mf5_pkg::hgt_t h_eff;
	logic          color_eff;
	mf5_pkg::row_t in_row_e;
	mf5_pkg::col_t in_col_e;
	mf5_pkg::row_t out_row_e;
	mf5_pkg::col_t out_col_e;
	mf5_pkg::lag_t lag_e;
	logic          live;
	logic          emit;
	logic          last;
	mf5_pkg::pix_t px;
	mf5_pkg::mask_t row_ok;
	mf5_pkg::mask_t col_ok;
	mf5_pkg::wid_t in_col_nx;
	mf5_pkg::wid_t out_col_nx;
	mf5_pkg::wr_req_t req;

	logic ov_s1, ov_s2, ov_s3, ov_s4, ov_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;
	mf5_pkg::mask_t row_ok_s1, row_ok_s2, col_ok_s1, col_ok_s2;
	mf5_pkg::win_t win;
	mf5_pkg::taps_t taps [mf5_pkg::CHANS];
	mf5_pkg::chan_t med [mf5_pkg::CHANS];

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= mf5_pkg::RST_FRAME_WIDTH;
			cfg_height_q <= mf5_pkg::RST_FRAME_HEIGHT;
			cfg_color_q  <= mf5_pkg::RST_COLOR_MODE;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				mf5_pkg::REG_FRAME_WIDTH:  cfg_width_q  <= pwdata[mf5_pkg::WID_W-1:0];
				mf5_pkg::REG_FRAME_HEIGHT: cfg_height_q <= pwdata[mf5_pkg::HGT_W-1:0];
				mf5_pkg::REG_COLOR_MODE:   cfg_color_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mf5_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_width_q);
			mf5_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_height_q);
			mf5_pkg::REG_COLOR_MODE:   prdata = 32'(cfg_color_q);
			default:                   prdata = '0;
		endcase
	end

	// Input stage: frame counters and the masks for the window that this word completes
	assign en        = !ov_s5 || res.ready;
	assign pix.ready = en;

	always_comb begin
		w_clamp = (cfg_width_q == '0) ? mf5_pkg::WID_W'(1) :
			((cfg_width_q > mf5_pkg::WID_W'(mf5_pkg::MAX_WIDTH)) ?
			mf5_pkg::WID_W'(mf5_pkg::MAX_WIDTH) : cfg_width_q);
		h_clamp = (cfg_height_q == '0) ? mf5_pkg::HGT_W'(1) :
			((cfg_height_q > mf5_pkg::HGT_W'(mf5_pkg::MAX_HEIGHT)) ?
			mf5_pkg::HGT_W'(mf5_pkg::MAX_HEIGHT) : cfg_height_q);
		start     = !busy_q && (pix.cmd == mf5_pkg::CMD_PIXEL);
		take      = pix.valid && en && (busy_q || start);
		w_eff     = start ? w_clamp : act_w_q;
		h_eff     = start ? h_clamp : act_h_q;
		color_eff = start ? cfg_color_q : act_color_q;
		in_row_e  = start ? '0 : in_row_q;
		in_col_e  = start ? '0 : in_col_q;
		out_row_e = start ? '0 : out_row_q;
		out_col_e = start ? '0 : out_col_q;
		lag_e     = start ? (mf5_pkg::LAG_W'(mf5_pkg::HALF) * mf5_pkg::LAG_W'(w_clamp)
			+ mf5_pkg::LAG_W'(mf5_pkg::HALF)) : lag_q;
		live      = (pix.cmd == mf5_pkg::CMD_PIXEL) && (in_row_e < mf5_pkg::ROW_W'(h_eff));
		px        = '0;
		if (live) begin
			px[7:0] = pix.chan0;
			if (color_eff) begin
				px[15:8]  = pix.chan1;
				px[23:16] = pix.chan2;
			end
		end
		emit = (lag_e == '0);
		last = emit && (out_row_e == mf5_pkg::ROW_W'(h_eff - 1'b1))
			&& ({1'b0, out_col_e} == w_eff - 1'b1);
		for (int i = 0; i < mf5_pkg::WINDOW; i++) begin
			row_ok[i] = ({1'b0, out_row_e} + (mf5_pkg::ROW_W+1)'(i)
				>= (mf5_pkg::ROW_W+1)'(mf5_pkg::HALF))
				&& ({1'b0, out_row_e} + (mf5_pkg::ROW_W+1)'(i)
				< {1'b0, h_eff} + (mf5_pkg::ROW_W+1)'(mf5_pkg::HALF));
			col_ok[i] = ({2'b0, out_col_e} + (mf5_pkg::WID_W+1)'(i)
				>= (mf5_pkg::WID_W+1)'(mf5_pkg::HALF))
				&& ({2'b0, out_col_e} + (mf5_pkg::WID_W+1)'(i)
				< {1'b0, w_eff} + (mf5_pkg::WID_W+1)'(mf5_pkg::HALF));
		end
		in_col_nx  = {1'b0, in_col_e} + 1'b1;
		out_col_nx = {1'b0, out_col_e} + 1'b1;
		req.valid  = take;
		req.col    = in_col_e;
		req.px     = px;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			act_w_q     <= mf5_pkg::RST_FRAME_WIDTH;
			act_h_q     <= mf5_pkg::RST_FRAME_HEIGHT;
			act_color_q <= mf5_pkg::RST_COLOR_MODE;
			in_row_q    <= '0;
			in_col_q    <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			lag_q       <= '0;
		end else if (take) begin
			busy_q      <= !last;
			act_w_q     <= w_eff;
			act_h_q     <= h_eff;
			act_color_q <= color_eff;
			if (in_col_nx >= w_eff) begin
				in_col_q <= '0;
				in_row_q <= in_row_e + 1'b1;
			end else begin
				in_col_q <= in_col_nx[mf5_pkg::COL_W-1:0];
				in_row_q <= in_row_e;
			end
			lag_q <= emit ? '0 : lag_e - 1'b1;
			if (emit) begin
				if (out_col_nx >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_e + 1'b1;
				end else begin
					out_col_q <= out_col_nx[mf5_pkg::COL_W-1:0];
					out_row_q <= out_row_e;
				end
			end else begin
				out_col_q <= out_col_e;
				out_row_q <= out_row_e;
			end
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s1 <= 1'b0;
			ov_s2 <= 1'b0;
			ov_s3 <= 1'b0;
			ov_s4 <= 1'b0;
			ov_s5 <= 1'b0;
		end else if (en) begin
			ov_s1 <= take && emit;
			ov_s2 <= ov_s1;
			ov_s3 <= ov_s2;
			ov_s4 <= ov_s3;
			ov_s5 <= ov_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1   <= last;
			last_s2   <= last_s1;
			last_s3   <= last_s2;
			last_s4   <= last_s3;
			last_s5   <= last_s4;
			row_ok_s1 <= row_ok;
			row_ok_s2 <= row_ok_s1;
			col_ok_s1 <= col_ok;
			col_ok_s2 <= col_ok_s1;
		end
	end

	mf5_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req    (req),
		.win    (win)
	);

	// Positions outside the image read as zero.
	always_comb begin
		for (int c = 0; c < mf5_pkg::CHANS; c++) begin
			for (int i = 0; i < mf5_pkg::WINDOW; i++) begin
				for (int j = 0; j < mf5_pkg::WINDOW; j++) begin
					taps[c][i*mf5_pkg::WINDOW+j] = (row_ok_s2[i] && col_ok_s2[j]) ?
						win[i][j][c*mf5_pkg::CW +: mf5_pkg::CW] : '0;
				end
			end
		end
	end

	for (genvar c = 0; c < mf5_pkg::CHANS; c++) begin : g_lane
		mf5_median_lane u_lane (
			.clk  (clk),
			.en   (en),
			.taps (taps[c]),
			.med  (med[c])
		);
	end

	assign res.valid     = ov_s5;
	assign res.med0      = med[0];
	assign res.med1      = med[1];
	assign res.med2      = med[2];
	assign res.frame_end = last_s5;

	`MF5_ASSERT(a_stall_blocks_input, res.valid && !res.ready |-> !pix.ready, "input taken while result stalled")
	`MF5_NEVER(a_in_col_bound, busy_q && ({1'b0, in_col_q} >= act_w_q), "input column past row end")
	`MF5_NEVER(a_out_row_bound, busy_q && (out_row_q >= mf5_pkg::ROW_W'(act_h_q)), "output row past frame")

endmodule

`default_nettype wire
